@@ rtl/core/apm_pkg.sv @@
// Shared types and constants for the approximate pattern match stream.
package apm_pkg;

   // Distance width, wide enough for the largest supported pattern
   localparam int DIST_W = 7;
   // Row index width, wide enough for any supported row
   localparam int ROW_W = 7;
   localparam int CHAR_W = 8;
   localparam int POS_W = 16;
   localparam int LEN_W = 5;
   localparam int THR_W = 5;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int OUT_DIST_W = 5;
   // Characters held in the two pattern registers
   localparam int REG_CHARS = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THRESHOLD = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 8'd3;

   localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;
   localparam logic [DIST_W-1:0] OUT_DIST_MAX = 7'd31;

   // Data handed from one cell to the next along with each text byte
   typedef struct packed {
      logic              valid;
      logic              start;
      logic [CHAR_W-1:0] text_char;
      logic [DIST_W-1:0] above;   // new distance of the row above
      logic [DIST_W-1:0] diag;    // previous distance of the row above
      logic [DIST_W-1:0] result;  // distance of the selected row
      logic [POS_W-1:0]  pos;
   } link_type;

endpackage

@@ rtl/core/apm_cell.sv @@
// One pattern row of the systolic distance chain.
module apm_cell #(
   parameter int ROW = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [apm_pkg::CHAR_W-1:0] pattern_char,
   input  logic [apm_pkg::ROW_W-1:0]  sel_row,
   input  apm_pkg::link_type          link_in,
   output apm_pkg::link_type          link_out
);

   localparam logic [apm_pkg::DIST_W-1:0] ROW_INIT = apm_pkg::DIST_W'(ROW + 1);
   localparam logic [apm_pkg::DIST_W-1:0] ONE = apm_pkg::DIST_W'(1);

   logic [apm_pkg::DIST_W-1:0] col_ff, col_in;
   logic                       valid_ff, valid_in;
   apm_pkg::link_type          data_ff, data_in;

   logic [apm_pkg::DIST_W-1:0] old_dist, diag_cost, del_cost, ins_cost, best;

   // Edit distance recurrence for this row
   always_comb begin
      old_dist  = link_in.start ? ROW_INIT : col_ff;
      diag_cost = link_in.diag + ((link_in.text_char == pattern_char) ?
                                  {apm_pkg::DIST_W{1'b0}} : ONE);
      del_cost  = link_in.above + ONE;
      ins_cost  = old_dist + ONE;
      best      = diag_cost;
      if (del_cost < best) begin
         best = del_cost;
      end
      if (ins_cost < best) begin
         best = ins_cost;
      end
   end

   // Next cell state and outgoing link
   always_comb begin
      col_in   = col_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = link_in.valid;
         data_in  = link_in;
         data_in.above = best;
         data_in.diag  = old_dist;
         if (sel_row == apm_pkg::ROW_W'(ROW)) begin
            data_in.result = best;
         end
         if (link_in.valid) begin
            col_in = best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= ROW_INIT;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      link_out       = data_ff;
      link_out.valid = valid_ff;
   end

endmodule

@@ rtl/core/approximate_pattern_match_stream.sv @@
// Top level: streaming approximate pattern matcher built from a chain of row cells.
//
//   channel  | direction | payload
//   req      | in        | tdata[7:0] text_char; tuser start_of_text
//   rsp      | out       | tdata[4:0] distance, [20:5] text_position; tuser is_match
//   csr      | in        | csr_index register, csr_wdata value
//
// One text byte enters per cycle while the chain advances; it walks the row chain
// one cell per cycle, through every row cell register and then the result register.
// Reset loads the distance column with row index plus one and clears position.
// A stalled result register freezes the chain only once the last cell holds a
// byte; bubbles ahead of it keep closing. Register writes are always taken.
module approximate_pattern_match_stream #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] text_char
   input  logic                           req_tuser,   // [0] start_of_text
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [4:0] distance, [20:5] text_position
   output logic                           rsp_tuser,   // [0] is_match
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [apm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [apm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [apm_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [apm_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic [apm_pkg::CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in;
   logic [apm_pkg::CSR_DATA_W-1:0] pat_hi_ff, pat_hi_in;

   logic [apm_pkg::POS_W-1:0]      pos_ff, pos_in, pos_item;
   logic [apm_pkg::ROW_W-1:0]      sel_row;
   logic [apm_pkg::ROW_W-1:0]      len_ext;
   logic                           advance;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [apm_pkg::OUT_DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [apm_pkg::POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                           rsp_match_ff, rsp_match_in;
   logic [apm_pkg::DIST_W-1:0]     last_dist;

   apm_pkg::link_type links [0:PATTERN_MAX];

   assign csr_ready = 1'b1;

   always_comb begin
      len_in    = len_ff;
      thr_in    = thr_ff;
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      if (csr_valid) begin
         case (csr_index)
            apm_pkg::CSR_PATTERN_LENGTH:  len_in    = csr_wdata[apm_pkg::LEN_W-1:0];
            apm_pkg::CSR_MATCH_THRESHOLD: thr_in    = csr_wdata[apm_pkg::THR_W-1:0];
            apm_pkg::CSR_PATTERN_LOW:     pat_lo_in = csr_wdata;
            apm_pkg::CSR_PATTERN_HIGH:    pat_hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= apm_pkg::LEN_W'(1);
         thr_ff    <= '0;
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
      end else begin
         len_ff    <= len_in;
         thr_ff    <= thr_in;
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
      end
   end

   // Reported row: length clamped to 1..PATTERN_MAX, minus one
   always_comb begin
      len_ext = apm_pkg::ROW_W'(len_ff);
      if (len_ext == '0) begin
         sel_row = '0;
      end else if (len_ext > apm_pkg::ROW_W'(PATTERN_MAX)) begin
         sel_row = apm_pkg::ROW_W'(PATTERN_MAX - 1);
      end else begin
         sel_row = len_ext - apm_pkg::ROW_W'(1);
      end
   end

   // Chain moves unless a finished byte sits on a held result
   assign advance    = !links[PATTERN_MAX].valid || !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Text position, saturating
   always_comb begin
      pos_item = req_tuser ? '0 : pos_ff;
      pos_in   = pos_ff;
      if (req_tvalid && advance) begin
         pos_in = (pos_item == apm_pkg::POS_MAX) ? apm_pkg::POS_MAX :
                  pos_item + apm_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Head of the chain: empty pattern prefix has distance zero
   always_comb begin
      links[0]           = '0;
      links[0].valid     = req_tvalid;
      links[0].start     = req_tuser;
      links[0].text_char = req_tdata;
      links[0].pos       = pos_item;
   end

   // Row cells
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_row
      logic [apm_pkg::CHAR_W-1:0] pchar;
      if (k < 8) begin : g_lo
         assign pchar = pat_lo_ff[8*k +: 8];
      end else if (k < apm_pkg::REG_CHARS) begin : g_hi
         assign pchar = pat_hi_ff[8*(k-8) +: 8];
      end else begin : g_none
         assign pchar = '0;
      end

      apm_cell #(
         .ROW (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .pattern_char (pchar),
         .sel_row      (sel_row),
         .link_in      (links[k]),
         .link_out     (links[k+1])
      );
   end

   // Result register
   always_comb begin
      last_dist    = links[PATTERN_MAX].result;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_match_in = rsp_match_ff;
      if (advance && links[PATTERN_MAX].valid) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = (last_dist > apm_pkg::OUT_DIST_MAX) ?
                        apm_pkg::OUT_DIST_W'(apm_pkg::OUT_DIST_MAX) :
                        last_dist[apm_pkg::OUT_DIST_W-1:0];
         rsp_pos_in   = links[PATTERN_MAX].pos;
         rsp_match_in = (rsp_dist_in <= thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff  <= rsp_dist_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pos_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_match_ff;

   // Back-pressure only comes from a held result with a byte waiting behind it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && links[PATTERN_MAX].valid))
      else $error("chain stalled without a held result");

   // Reported row always lies inside the chain
   a_sel_row: assert property (@(posedge clock) disable iff (reset)
      sel_row < apm_pkg::ROW_W'(PATTERN_MAX))
      else $error("selected row out of range");

   // Reported distance never exceeds the pattern size
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (apm_pkg::DIST_W'(rsp_dist_ff) <= apm_pkg::DIST_W'(PATTERN_MAX)))
      else $error("distance above pattern size");

   // Position counter holds at saturation until a new text starts
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == apm_pkg::POS_MAX && !(req_tvalid && req_tready && req_tuser))
      |=> pos_ff == apm_pkg::POS_MAX)
      else $error("position counter wrapped");

endmodule
